### design/mwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared widths, register indexes and constants of the mecanum wheel mixer.
// ----------------------------------------------------------------------------
package mwm_pkg;

   localparam int NUM_WHEELS  = 4;
   localparam int MASK_W      = 4;
   localparam int SCALE_W     = 10;
   localparam int BLEED_W     = 16;
   localparam int OUT_W       = 11;
   localparam int Q_BITS      = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_WHEEL_MASK   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_SCALE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROT_BLEED    = 2'd2;

   localparam logic [MASK_W-1:0]  MASK_RESET  = 4'd0;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd512;
   localparam logic [BLEED_W-1:0] BLEED_RESET = 16'd655;

   localparam int BLEED_HALF = 32768;

endpackage

### design/mwm_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwm_sqrt
// Pipelined integer square root, one root bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module mwm_sqrt import mwm_pkg::*; #(
   parameter int W  = 16,
   parameter int TW = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [2*W-1:0]   in_rad,
   input  logic [TW-1:0]    in_tag,
   output logic             out_valid,
   output logic [W-1:0]     out_root,
   output logic [TW-1:0]    out_tag
);

   localparam int RW = W + 2;

   logic [W-1:0]   valid_ff;
   logic [RW-1:0]  rem_ff  [W];
   logic [W-1:0]   root_ff [W];
   logic [2*W-1:0] rad_ff  [W];
   logic [TW-1:0]  tag_ff  [W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic [RW-1:0]  rem_prev;
      logic [W-1:0]   root_prev;
      logic [2*W-1:0] rad_prev;
      logic [TW-1:0]  tag_prev;
      logic           valid_prev;
      logic [RW:0]    cur;
      logic [RW:0]    trial;
      logic [RW:0]    diff;
      logic           ge;

      if (k == 0) begin : g_first
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = in_rad;
         assign tag_prev   = in_tag;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign cur   = {rem_prev[RW-2:0], rad_prev[2*W-1 -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};
      assign ge    = cur >= trial;
      assign diff  = cur - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? diff[RW-1:0] : cur[RW-1:0];
            root_ff[k] <= {root_prev[W-2:0], ge};
            rad_ff[k]  <= {rad_prev[2*W-3:0], 2'b00};
            tag_ff[k]  <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[W-1];
   assign out_root  = root_ff[W-1];
   assign out_tag   = tag_ff[W-1];

endmodule

### design/mwm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwm_div
// Four-lane pipelined rounding divider, one quotient bit per stage.
// Gives (2a + den) / (2 den) for each lane against a shared divisor.
// ----------------------------------------------------------------------------
module mwm_div import mwm_pkg::*; #(
   parameter int AW = 28,
   parameter int DW = 18,
   parameter int TW = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [AW-1:0]     in_num [NUM_WHEELS],
   input  logic [DW-1:0]     in_den,
   input  logic [TW-1:0]     in_tag,
   output logic              out_valid,
   output logic [Q_BITS-1:0] out_quo [NUM_WHEELS],
   output logic [TW-1:0]     out_tag
);

   localparam int NW = AW + 2;

   logic [Q_BITS-1:0] valid_ff;
   logic [NW-1:0]     rem_ff [Q_BITS][NUM_WHEELS];
   logic [Q_BITS-1:0] quo_ff [Q_BITS][NUM_WHEELS];
   logic [DW:0]       div_ff [Q_BITS];
   logic [TW-1:0]     tag_ff [Q_BITS];

   for (genvar j = 0; j < Q_BITS; j++) begin : g_stage
      logic [DW:0]   div_prev;
      logic [TW-1:0] tag_prev;
      logic          valid_prev;
      logic [NW-1:0] div_sh;

      if (j == 0) begin : g_first
         assign div_prev   = {in_den, 1'b0};
         assign tag_prev   = in_tag;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign div_prev   = div_ff[j-1];
         assign tag_prev   = tag_ff[j-1];
         assign valid_prev = valid_ff[j-1];
      end

      assign div_sh = NW'(div_prev) << (Q_BITS - 1 - j);

      for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_lane
         logic [NW-1:0]     rem_prev;
         logic [Q_BITS-1:0] quo_prev;
         logic              ge;

         if (j == 0) begin : g_first
            assign rem_prev = (NW'(in_num[i]) << 1) + NW'(in_den);
            assign quo_prev = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[j-1][i];
            assign quo_prev = quo_ff[j-1][i];
         end

         assign ge = rem_prev >= div_sh;

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j][i] <= ge ? (rem_prev - div_sh) : rem_prev;
               quo_ff[j][i] <= {quo_prev[Q_BITS-2:0], ge};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[j] <= div_prev;
            tag_ff[j] <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[Q_BITS-1];
   assign out_quo   = quo_ff[Q_BITS-1];
   assign out_tag   = tag_ff[Q_BITS-1];

endmodule

### design/mecanum_wheel_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer
// Mecanum drive inverse kinematics: drive command in, four wheel setpoints out.
// ----------------------------------------------------------------------------
// Commands arrive on the req_ stream (x, y, rotation, signed Q2.(W-2)); one
// result per command leaves on the rsp_ stream with the four wheel setpoints
// and the normalisation flag. The csr_ port writes the reversal mask, output
// scale and rotation bleed; write it only while the pipeline is empty.
// Throughput is one command per cycle while the receiver does not stall. The
// path from a req_ transfer to the rsp_ result has COMMAND_WIDTH + 17 register
// stages, the output register included: one stage per square root bit, one per
// quotient bit, and seven stages for the multipliers, wheel sums, maximum
// search and output.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, the whole pipeline holds and req_tready drops;
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer import mwm_pkg::*; #(
   parameter int COMMAND_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // cmd_x, cmd_y, cmd_rotation
   input  logic [((3*COMMAND_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // left_front, right_front, left_rear, right_rear setpoints, was_normalized
   output logic [47:0]                  rsp_tdata,
   input  logic                         csr_we,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int W  = COMMAND_WIDTH;
   localparam int WW = W + 3;
   localparam int DW = W + 2;
   localparam int AW = DW + SCALE_W;
   localparam int TW = 3 * W;
   localparam logic [DW-1:0] ONE = DW'(1) << (W - 2);

   logic [MASK_W-1:0]  mask_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [BLEED_W-1:0] bleed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= MASK_RESET;
         scale_ff <= SCALE_RESET;
         bleed_ff <= BLEED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WHEEL_MASK:   mask_ff  <= csr_wdata[MASK_W-1:0];
            REG_OUTPUT_SCALE: scale_ff <= csr_wdata[SCALE_W-1:0];
            REG_ROT_BLEED:    bleed_ff <= csr_wdata[BLEED_W-1:0];
            default:          ;
         endcase
      end
   end

   logic adv;
   logic rsp_tvalid_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: capture
   logic                s1_valid_ff;
   logic signed [W-1:0] s1_x_ff, s1_y_ff, s1_r_ff;

   // stage 2: squares
   logic                  s2_valid_ff;
   logic signed [2*W-1:0] s2_xx_ff, s2_yy_ff;
   logic [TW-1:0]         s2_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff   <= req_tdata[W-1:0];
         s1_y_ff   <= req_tdata[2*W-1:W];
         s1_r_ff   <= req_tdata[3*W-1:2*W];
         s2_xx_ff  <= (2*W)'(s1_x_ff) * (2*W)'(s1_x_ff);
         s2_yy_ff  <= (2*W)'(s1_y_ff) * (2*W)'(s1_y_ff);
         s2_tag_ff <= {s1_r_ff, s1_y_ff, s1_x_ff};
      end
   end

   logic [2*W-1:0] sq_sum;
   logic           sq_valid;
   logic [W-1:0]   sq_root;
   logic [TW-1:0]  sq_tag;

   assign sq_sum = s2_xx_ff + s2_yy_ff;

   mwm_sqrt #(
      .W  (W),
      .TW (TW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s2_valid_ff),
      .in_rad    (sq_sum),
      .in_tag    (s2_tag_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // stage 3: bleed product
   logic            s3_valid_ff;
   logic [W+15:0]   s3_prod_ff;
   logic [TW-1:0]   s3_tag_ff;

   // stage 4: wheel sums
   logic                 s4_valid_ff;
   logic signed [WW-1:0] s4_w_ff [NUM_WHEELS];

   logic [W+16:0]        bl_sum;
   logic [W:0]           bleed_term;
   logic signed [WW-1:0] ex, ey, er, rot;
   logic signed [WW-1:0] w_in [NUM_WHEELS];

   assign bl_sum     = (W+17)'(s3_prod_ff) + (W+17)'(BLEED_HALF);
   assign bleed_term = bl_sum[W+16:16];
   assign ex         = WW'($signed(s3_tag_ff[W-1:0]));
   assign ey         = WW'($signed(s3_tag_ff[2*W-1:W]));
   assign er         = WW'($signed(s3_tag_ff[3*W-1:2*W]));
   assign rot        = -er - $signed(WW'(bleed_term));
   assign w_in[0]    = ey + ex + rot;
   assign w_in[1]    = -ey + ex - rot;
   assign w_in[2]    = -ey + ex + rot;
   assign w_in[3]    = ey + ex - rot;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= sq_valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_prod_ff <= (W+16)'(sq_root) * (W+16)'(bleed_ff);
         s3_tag_ff  <= sq_tag;
         s4_w_ff    <= w_in;
      end
   end

   // stage 5: magnitudes, maximum, divisor
   logic                  s5_valid_ff;
   logic [DW-1:0]         s5_abs_ff [NUM_WHEELS];
   logic [DW-1:0]         s5_den_ff;
   logic                  s5_norm_ff;
   logic [NUM_WHEELS-1:0] s5_neg_ff;

   logic [DW-1:0]         abs_in [NUM_WHEELS];
   logic [NUM_WHEELS-1:0] neg_in;
   logic [DW-1:0]         max_a, max_b, max_in;
   logic                  norm_in;

   for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_abs
      logic signed [WW-1:0] mag;
      assign mag       = s4_w_ff[i][WW-1] ? -s4_w_ff[i] : s4_w_ff[i];
      assign abs_in[i] = mag[DW-1:0];
      assign neg_in[i] = s4_w_ff[i][WW-1] ^ mask_ff[i];
   end

   assign max_a   = (abs_in[0] > abs_in[1]) ? abs_in[0] : abs_in[1];
   assign max_b   = (abs_in[2] > abs_in[3]) ? abs_in[2] : abs_in[3];
   assign max_in  = (max_a > max_b) ? max_a : max_b;
   assign norm_in = max_in > ONE;

   // stage 6: scale
   logic                  s6_valid_ff;
   logic [AW-1:0]         s6_num_ff [NUM_WHEELS];
   logic [DW-1:0]         s6_den_ff;
   logic [NUM_WHEELS:0]   s6_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_abs_ff  <= abs_in;
         s5_norm_ff <= norm_in;
         s5_den_ff  <= norm_in ? max_in : ONE;
         s5_neg_ff  <= neg_in;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            s6_num_ff[i] <= AW'(s5_abs_ff[i]) * AW'(scale_ff);
         end
         s6_den_ff <= s5_den_ff;
         s6_tag_ff <= {s5_norm_ff, s5_neg_ff};
      end
   end

   logic              dv_valid;
   logic [Q_BITS-1:0] dv_quo [NUM_WHEELS];
   logic [NUM_WHEELS:0] dv_tag;

   mwm_div #(
      .AW (AW),
      .DW (DW),
      .TW (NUM_WHEELS + 1)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s6_valid_ff),
      .in_num    (s6_num_ff),
      .in_den    (s6_den_ff),
      .in_tag    (s6_tag_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_tag   (dv_tag)
   );

   // output register: saturate and apply sign
   logic [47:0]          rsp_tdata_ff;
   logic [OUT_W-1:0]     sp_in [NUM_WHEELS];

   for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_out
      logic [OUT_W-1:0] mag;
      assign mag      = (OUT_W'(dv_quo[i]) > OUT_W'(1023)) ? OUT_W'(1023) : OUT_W'(dv_quo[i]);
      assign sp_in[i] = dv_tag[i] ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= {3'b000, dv_tag[NUM_WHEELS], sp_in[3], sp_in[2], sp_in[1], sp_in[0]};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_den_one: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff && !s5_norm_ff |-> s5_den_ff == ONE)
      else $error("divisor not 1.0 without normalisation");

   a_den_max: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> s5_den_ff >= s5_abs_ff[0] || !s5_norm_ff)
      else $error("divisor below a wheel magnitude");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[OUT_W-1:0] != 11'h400
         && rsp_tdata[2*OUT_W-1:OUT_W] != 11'h400)
      else $error("setpoint out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule
